// ===== rtl/vlip_pkg.sv =====
// Shared constants, types and command/status bundles for the varispeed player.
`default_nettype none
package vlip_pkg;

    localparam int MAX_SAMPLES  = 65536;
    localparam int MAX_CHANNELS = 8;
    localparam int ADDR_W       = $clog2(MAX_SAMPLES);
    localparam int FILL_W       = ADDR_W + 1;
    localparam int CH_W         = 4;
    localparam int CHI_W        = 3;
    localparam int SR_W         = 18;
    localparam int POS_W        = 34;
    localparam int FRAC_W       = 12;
    localparam int ILO_W        = POS_W - 1 - FRAC_W;

    localparam logic [SR_W-1:0] SR_RESET = 18'd48000;
    localparam logic [CH_W-1:0] CH_RESET = 4'd2;
    localparam logic signed [15:0] QUIET_SPEED = 16'sd41;

    // Request codes.
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_BEGIN  = 2'd2;
    localparam logic [1:0] REQ_NEXT   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHANNELS    = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd1;

    typedef struct packed {
        logic latch_in;
        logic mul_dur;
        logic set_pos;
        logic set_budget;
        logic do_append;
        logic do_clear;
        logic frame_setup;
        logic rd_lo;
        logic rd_hi;
        logic cap_lo;
        logic cap_hi;
        logic mul_diff;
        logic emit;
        logic ch_next;
        logic frame_adv;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       frames_zero;
        logic       ch_last;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/varispeed_linear_interp_player.sv =====
// Append/clear beats end after decode; a begin beat sets the position, then the frame budget.
// A next-frame beat with frames left emits one result per channel, each after two reads and a multiply.
// Busy stays high until the beat is done; the single-port sample store sets the pace.
// Results are shown for one cycle each; the receiver cannot stall.
// Synchronous active-low reset clears control state; the store needs no clearing pass.
`default_nettype none
module varispeed_linear_interp_player
    import vlip_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [SR_W-1:0]    i_cfg_data,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [15:0] i_sample_in,
    input  wire logic signed [31:0] i_start_time,
    input  wire logic [31:0]        i_duration,
    input  wire logic signed [15:0] i_speed,
    output logic                    o_valid,
    output logic signed [15:0]      o_sample_out,
    output logic [CHI_W-1:0]        o_channel_index,
    output logic                    o_frame_last,
    output logic                    o_scrub_last
);
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    vlip_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_status(status),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    vlip_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_sample_in    (i_sample_in),
        .i_start_time   (i_start_time),
        .i_duration     (i_duration),
        .i_speed        (i_speed),
        .o_valid        (o_valid),
        .o_sample_out   (o_sample_out),
        .o_channel_index(o_channel_index),
        .o_frame_last   (o_frame_last),
        .o_scrub_last   (o_scrub_last)
    );
endmodule
`default_nettype wire

// ===== rtl/vlip_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module vlip_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One address per cycle: optional write, plus a registered read of the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/vlip_ctrl.sv =====
// Controller state machine sequencing requests and per-channel interpolation.
`default_nettype none
module vlip_ctrl
    import vlip_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output logic         o_busy,
    output t_cmd         o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_DECODE  = 11'b00000000010,
        S_MUL_POS = 11'b00000000100,
        S_MUL_DUR = 11'b00000001000,
        S_SETUP   = 11'b00000010000,
        S_RD_LO   = 11'b00000100000,
        S_RD_HI   = 11'b00001000000,
        S_WAIT_HI = 11'b00010000000,
        S_INTERP  = 11'b00100000000,
        S_EMIT    = 11'b01000000000,
        S_ADV     = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.req)
                    REQ_APPEND: begin
                        o_cmd.do_append = 1'b1;
                        n_state = S_IDLE;
                    end
                    REQ_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                        n_state = S_IDLE;
                    end
                    REQ_BEGIN: n_state = S_MUL_POS;
                    default: begin
                        n_state = i_status.frames_zero ? S_IDLE : S_SETUP;
                    end
                endcase
            end
            S_MUL_POS: begin
                o_cmd.set_pos = 1'b1;
                o_cmd.mul_dur = 1'b1;
                n_state = S_MUL_DUR;
            end
            S_MUL_DUR: begin
                o_cmd.set_budget = 1'b1;
                n_state = S_IDLE;
            end
            S_SETUP: begin
                o_cmd.frame_setup = 1'b1;
                n_state = S_RD_LO;
            end
            S_RD_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd.rd_hi  = 1'b1;
                o_cmd.cap_lo = 1'b1;
                n_state = S_WAIT_HI;
            end
            S_WAIT_HI: begin
                o_cmd.cap_hi = 1'b1;
                n_state = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.mul_diff = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.ch_last) begin
                    n_state = S_ADV;
                end else begin
                    o_cmd.ch_next = 1'b1;
                    n_state = S_RD_LO;
                end
            end
            S_ADV: begin
                o_cmd.frame_adv = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/vlip_dp.sv =====
// Datapath: configuration, sample store, scrub state and interpolation.
`default_nettype none
module vlip_dp
    import vlip_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic              i_cfg_valid,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [SR_W-1:0]   i_cfg_data,
    input  wire logic [1:0]        i_req_type,
    input  wire logic signed [15:0] i_sample_in,
    input  wire logic signed [31:0] i_start_time,
    input  wire logic [31:0]       i_duration,
    input  wire logic signed [15:0] i_speed,
    output logic                   o_valid,
    output logic signed [15:0]     o_sample_out,
    output logic [CHI_W-1:0]       o_channel_index,
    output logic                   o_frame_last,
    output logic                   o_scrub_last
);
    // Configuration registers.
    logic [CH_W-1:0] r_channels;
    logic [SR_W-1:0] r_sample_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels    <= CH_RESET;
            r_sample_rate <= SR_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CHANNELS) begin
                r_channels <= i_cfg_data[CH_W-1:0];
            end else if (i_cfg_index == CFG_SAMPLE_RATE) begin
                r_sample_rate <= i_cfg_data;
            end
        end
    end

    // Effective channel count, clamped to one through the maximum.
    logic [CH_W-1:0] nch;
    always_comb begin
        if (r_channels == '0) begin
            nch = CH_W'(1);
        end else if (r_channels > CH_W'(MAX_CHANNELS)) begin
            nch = CH_W'(MAX_CHANNELS);
        end else begin
            nch = r_channels;
        end
    end

    // Input beat capture.
    logic [1:0]         r_req;
    logic signed [15:0] r_sample;
    logic signed [31:0] r_start;
    logic [31:0]        r_dur;
    logic signed [15:0] r_spd_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_req    <= i_req_type;
            r_sample <= i_sample_in;
            r_start  <= i_start_time;
            r_dur    <= i_duration;
            r_spd_in <= i_speed;
        end
    end

    // Scrub and store state.
    logic [FILL_W-1:0]       r_fill;
    logic signed [POS_W-1:0] r_pos;
    logic signed [15:0]      r_speed;
    logic [POS_W-1:0]        r_frames;
    logic                    r_quiet;
    logic                    spd_quiet;
    logic                    store_full;

    // Shared time-to-frames multiplier.
    logic signed [32:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [51:0] r_mul;
    assign mul_a = i_cmd.mul_dur ? $signed({1'b0, r_dur}) : $signed({r_start[31], r_start});
    assign mul_b = $signed({1'b0, r_sample_rate});

    always_ff @(posedge i_clk) begin
        r_mul <= 52'(mul_a * mul_b);
    end

    // Start position: floor of product / 16, saturated.
    logic signed [47:0]      pos_shift;
    logic signed [POS_W-1:0] pos_sat;
    assign pos_shift = 48'(r_mul >>> 4);
    always_comb begin
        if (pos_shift[47:POS_W-1] == '0 || pos_shift[47:POS_W-1] == '1) begin
            pos_sat = pos_shift[POS_W-1:0];
        end else if (pos_shift[47]) begin
            pos_sat = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            pos_sat = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    // Position advance by speed, saturated.
    logic signed [POS_W:0]   pos_sum;
    logic signed [POS_W-1:0] pos_next;
    assign pos_sum = $signed({r_pos[POS_W-1], r_pos}) + (POS_W+1)'(r_speed);
    always_comb begin
        if (pos_sum[POS_W] == pos_sum[POS_W-1]) begin
            pos_next = pos_sum[POS_W-1:0];
        end else if (pos_sum[POS_W]) begin
            pos_next = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            pos_next = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    assign spd_quiet  = (r_spd_in < QUIET_SPEED) && (r_spd_in > -QUIET_SPEED);
    assign store_full = (r_fill == FILL_W'(MAX_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_pos    <= '0;
            r_speed  <= '0;
            r_frames <= '0;
            r_quiet  <= 1'b1;
        end else begin
            if (i_cmd.do_append && !store_full) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (i_cmd.do_clear) begin
                r_fill <= '0;
            end
            if (i_cmd.set_pos) begin
                r_pos <= pos_sat;
            end
            if (i_cmd.set_budget) begin
                r_frames <= r_mul[POS_W+15:16];
                r_speed  <= r_spd_in;
                r_quiet  <= (r_fill == '0) || spd_quiet;
            end
            if (i_cmd.frame_adv) begin
                r_frames <= r_frames - POS_W'(1);
                r_pos    <= pos_next;
            end
        end
    end

    // Frame setup: base address and range test.
    logic [ILO_W-1:0]    ilo;
    logic [ILO_W:0]      ilo2;
    logic [ILO_W+4:0]    need;
    logic [ILO_W+3:0]    r_base;
    logic                r_in_range;
    logic [FRAC_W-1:0]   r_frac;
    logic [CHI_W-1:0]    r_ch;

    assign ilo  = r_pos[POS_W-2:FRAC_W];
    assign ilo2 = {1'b0, ilo} + (ILO_W+1)'(2);
    assign need = (ILO_W+5)'(ilo2 * nch);

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_setup) begin
            r_base     <= (ILO_W+4)'(ilo * nch);
            r_in_range <= !r_quiet && !r_pos[POS_W-1] && (need <= (ILO_W+5)'(r_fill));
            r_frac     <= r_pos[FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_setup) begin
            r_ch <= '0;
        end else if (i_cmd.ch_next) begin
            r_ch <= r_ch + CHI_W'(1);
        end
    end

    // Sample store access.
    logic [ADDR_W-1:0] addr_lo;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [15:0]       ram_rdata;

    assign addr_lo = r_base[ADDR_W-1:0] + ADDR_W'(r_ch);
    assign addr_hi = addr_lo + ADDR_W'(nch);
    assign ram_we  = i_cmd.do_append && !store_full;
    always_comb begin
        if (i_cmd.rd_hi) begin
            ram_addr = addr_hi;
        end else if (i_cmd.rd_lo) begin
            ram_addr = addr_lo;
        end else begin
            ram_addr = r_fill[ADDR_W-1:0];
        end
    end

    vlip_ram #(
        .WIDTH(16),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_sample),
        .o_rdata(ram_rdata)
    );

    // Interpolation: lo + round((hi - lo) * f / 4096).
    logic signed [15:0] r_lo;
    logic signed [15:0] r_hi;
    logic signed [29:0] r_prod;
    logic signed [16:0] diff;
    logic signed [29:0] prod_rnd;
    logic signed [17:0] interp;

    assign diff     = 17'(r_hi) - 17'(r_lo);
    assign prod_rnd = r_prod + 30'sd2048;
    assign interp   = 18'(r_lo) + 18'(prod_rnd >>> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_lo) begin
            r_lo <= ram_rdata;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= ram_rdata;
        end
        if (i_cmd.mul_diff) begin
            r_prod <= 30'(diff * $signed({1'b0, r_frac}));
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_sample_out    <= r_in_range ? interp[15:0] : 16'sd0;
            o_channel_index <= r_ch;
            o_frame_last    <= (CH_W'(r_ch) == nch - CH_W'(1));
            o_scrub_last    <= (r_frames == POS_W'(1));
        end
    end

    assign o_status.req         = r_req;
    assign o_status.frames_zero = (r_frames == '0);
    assign o_status.ch_last     = (CH_W'(r_ch) == nch - CH_W'(1));
endmodule
`default_nettype wire
